@@ sv/mrwt_pkg.sv @@
// Package for the Miller-Rabin witness test block.
// Holds the number width, verdict codes and controller state type.
package mrwt_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int BIT_W     = $clog2(NUM_WIDTH);

    typedef enum logic [1:0] {
        VERDICT_PASS      = 2'd0,
        VERDICT_BELOW_TWO = 2'd1,
        VERDICT_EVEN      = 2'd2,
        VERDICT_COMPOSITE = 2'd3
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_SPLIT,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_TEST,
        ST_SQ,
        ST_SQ_TEST,
        ST_OUT
    } state_t;

    // Datapath operation for the current cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_STEP,
        OP_SPLIT_STEP,
        OP_POW_INIT,
        OP_MUL_START_ACC,
        OP_MUL_START_SQ,
        OP_MUL_START_X,
        OP_MUL_STEP,
        OP_MUL_DONE_ACC,
        OP_MUL_DONE_SQ,
        OP_MUL_DONE_X,
        OP_X_FROM_ACC
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic p_lt2;
        logic p_eq2;
        logic p_even;
        logic red_done;
        logic s_odd;
        logic exp_zero;
        logic exp_lsb;
        logic mul_last;
        logic x_eq1;
        logic x_eqpm1;
        logic r_done;
    } dp_status_t;

endpackage

@@ sv/mrwt_datapath.sv @@
// Datapath: operand registers, bit-serial modular multiplier, witness reduction.
// Depends on mrwt_pkg; driven by mrwt_ctrl through dp_cmd_t.
module mrwt_datapath
    import mrwt_pkg::*;
(
    input  logic                 clk,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic [NUM_WIDTH-1:0] witness,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    logic [NUM_WIDTH-1:0] p_reg, p_next;
    logic [NUM_WIDTH-1:0] w_reg, w_next;     // witness, shifted out during reduction
    logic [NUM_WIDTH-1:0] rem_reg, rem_next; // remainder during reduction
    logic [NUM_WIDTH-1:0] s_reg, s_next;     // exponent
    logic [NUM_WIDTH-1:0] r_reg, r_next;     // squarings left (thermometer count)
    logic [NUM_WIDTH-1:0] acc_reg, acc_next;
    logic [NUM_WIDTH-1:0] sq_reg, sq_next;
    logic [NUM_WIDTH-1:0] x_reg, x_next;
    logic [NUM_WIDTH-1:0] ma_reg, ma_next;   // multiplicand
    logic [NUM_WIDTH-1:0] mb_reg, mb_next;   // multiplier, shifts left
    logic [NUM_WIDTH-1:0] mp_reg, mp_next;   // partial product
    logic [BIT_W-1:0]     bit_reg, bit_next;

    logic [NUM_WIDTH-1:0] pm1;
    logic [NUM_WIDTH-1:0] dbl, sum;
    logic [NUM_WIDTH:0]   rem2;

    // (a + b) mod p for a, b < p
    function automatic logic [NUM_WIDTH-1:0] add_mod(
        input logic [NUM_WIDTH-1:0] a,
        input logic [NUM_WIDTH-1:0] b,
        input logic [NUM_WIDTH-1:0] m
    );
        logic [NUM_WIDTH-1:0] room;
        room = m - b;
        add_mod = (a >= room) ? (a - room) : (a + b);
    endfunction

    assign pm1  = p_reg - {{(NUM_WIDTH-1){1'b0}}, 1'b1};
    assign dbl  = add_mod(mp_reg, mp_reg, p_reg);
    assign sum  = mb_reg[NUM_WIDTH-1] ? add_mod(dbl, ma_reg, p_reg) : dbl;
    assign rem2 = {rem_reg, w_reg[NUM_WIDTH-1]};

    always_comb
    begin
        p_next   = p_reg;
        w_next   = w_reg;
        rem_next = rem_reg;
        s_next   = s_reg;
        r_next   = r_reg;
        acc_next = acc_reg;
        sq_next  = sq_reg;
        x_next   = x_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        mp_next  = mp_reg;
        bit_next = bit_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                p_next   = candidate;
                w_next   = witness;
                rem_next = '0;
                bit_next = '0;
                s_next   = candidate - {{(NUM_WIDTH-1){1'b0}}, 1'b1};
                r_next   = '0;
            end
            OP_RED_STEP:
            begin
                // restoring division, one quotient bit a cycle
                if (rem2 >= {1'b0, p_reg})
                    rem_next = rem2[NUM_WIDTH-1:0] - p_reg;
                else
                    rem_next = rem2[NUM_WIDTH-1:0];
                w_next   = {w_reg[NUM_WIDTH-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
            end
            OP_SPLIT_STEP:
            begin
                s_next = {1'b0, s_reg[NUM_WIDTH-1:1]};
                r_next = {r_reg[NUM_WIDTH-2:0], 1'b1};
            end
            OP_POW_INIT:
            begin
                acc_next = {{(NUM_WIDTH-1){1'b0}}, 1'b1};
                sq_next  = rem_reg;
            end
            OP_MUL_START_ACC:
            begin
                ma_next = acc_reg; mb_next = sq_reg; mp_next = '0; bit_next = '0;
            end
            OP_MUL_START_SQ:
            begin
                ma_next = sq_reg; mb_next = sq_reg; mp_next = '0; bit_next = '0;
            end
            OP_MUL_START_X:
            begin
                ma_next = x_reg; mb_next = x_reg; mp_next = '0; bit_next = '0;
            end
            OP_MUL_STEP:
            begin
                mp_next  = sum;
                mb_next  = {mb_reg[NUM_WIDTH-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
            end
            OP_MUL_DONE_ACC: acc_next = mp_reg;
            OP_MUL_DONE_SQ:
            begin
                // square done: advance to the next exponent bit
                sq_next = mp_reg;
                s_next  = {1'b0, s_reg[NUM_WIDTH-1:1]};
            end
            OP_MUL_DONE_X:
            begin
                x_next = mp_reg;
                r_next = {1'b0, r_reg[NUM_WIDTH-1:1]};
            end
            OP_X_FROM_ACC:
            begin
                x_next = acc_reg;
                r_next = {1'b0, r_reg[NUM_WIDTH-1:1]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        w_reg   <= w_next;
        rem_reg <= rem_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        x_reg   <= x_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        mp_reg  <= mp_next;
        bit_reg <= bit_next;
    end

    assign status.p_lt2    = (p_reg[NUM_WIDTH-1:1] == '0);
    assign status.p_eq2    = (p_reg == {{(NUM_WIDTH-2){1'b0}}, 2'b10});
    assign status.p_even   = ~p_reg[0];
    assign status.red_done = (bit_reg == BIT_W'(NUM_WIDTH-1));
    assign status.s_odd    = s_reg[0];
    assign status.exp_zero = (s_reg == '0);
    assign status.exp_lsb  = s_reg[0];
    assign status.mul_last = (bit_reg == BIT_W'(NUM_WIDTH-1));
    assign status.x_eq1    = (x_reg == {{(NUM_WIDTH-1){1'b0}}, 1'b1});
    assign status.x_eqpm1  = (x_reg == pm1);
    assign status.r_done   = (r_reg == '0);

endmodule

@@ sv/mrwt_ctrl.sv @@
// Controller state machine sequencing one Miller-Rabin round.
// Depends on mrwt_pkg; commands mrwt_datapath.
module mrwt_ctrl
    import mrwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_fire,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       out_valid,
    output verdict_t   verdict
);

    state_t   state_reg, state_next;
    verdict_t verdict_reg, verdict_next;
    logic     mul_sq_reg, mul_sq_next; // pow: squaring after the acc product
    logic     x_first_reg, x_first_next; // x not yet squared

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= VERDICT_PASS;
            mul_sq_reg  <= 1'b0;
            x_first_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            mul_sq_reg  <= mul_sq_next;
            x_first_reg <= x_first_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        mul_sq_next  = mul_sq_reg;
        x_first_next = x_first_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.p_lt2)
                begin
                    verdict_next = VERDICT_BELOW_TWO; state_next = ST_OUT;
                end
                else if (status.p_eq2)
                begin
                    verdict_next = VERDICT_PASS; state_next = ST_OUT;
                end
                else if (status.p_even)
                begin
                    verdict_next = VERDICT_EVEN; state_next = ST_OUT;
                end
                else
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.op = OP_RED_STEP;
                if (status.red_done)
                    state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (status.s_odd)
                begin
                    cmd.op      = OP_POW_INIT;
                    mul_sq_next = 1'b0;
                    state_next  = ST_POW_STEP;
                end
                else
                    cmd.op = OP_SPLIT_STEP;
            end
            ST_POW_STEP:
            begin
                // s is odd and nonzero at start
                if (status.exp_zero)
                begin
                    cmd.op       = OP_X_FROM_ACC;
                    x_first_next = 1'b1;
                    state_next   = ST_TEST;
                end
                else if (status.exp_lsb && !mul_sq_reg)
                begin
                    cmd.op      = OP_MUL_START_ACC;
                    mul_sq_next = 1'b0;
                    state_next  = ST_POW_MUL;
                end
                else
                begin
                    cmd.op      = OP_MUL_START_SQ;
                    mul_sq_next = 1'b1;
                    state_next  = ST_POW_MUL;
                end
            end
            ST_POW_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.mul_last)
                    state_next = ST_POW_SQ;
            end
            ST_POW_SQ:
            begin
                if (!mul_sq_reg)
                begin
                    cmd.op      = OP_MUL_DONE_ACC;
                    mul_sq_next = 1'b1;
                    state_next  = ST_POW_STEP;
                end
                else
                begin
                    cmd.op      = OP_MUL_DONE_SQ;
                    mul_sq_next = 1'b0;
                    state_next  = ST_POW_STEP;
                end
            end
            ST_TEST:
            begin
                // x of one passes only before the first squaring
                if (status.x_eqpm1 || (status.x_eq1 && x_first_reg))
                begin
                    verdict_next = VERDICT_PASS; state_next = ST_OUT;
                end
                else if (status.r_done || status.x_eq1)
                begin
                    verdict_next = VERDICT_COMPOSITE; state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_MUL_START_X;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.mul_last)
                    state_next = ST_SQ_TEST;
            end
            ST_SQ_TEST:
            begin
                cmd.op       = OP_MUL_DONE_X;
                x_first_next = 1'b0;
                state_next   = ST_TEST;
            end
            ST_OUT:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign verdict   = verdict_reg;

endmodule

@@ sv/miller_rabin_witness_test.sv @@
// channel  | dir | tdata bits                          | handshake
// s_axis   | in  | [63:0] candidate, [127:64] witness  | s_axis_tvalid/tready
// m_axis   | out | [0] probable_prime, [2:1] verdict   | m_axis_tvalid/tready
// One item at a time. Trivial candidates (below two, two, even) go straight to the result;
// odd ones run the witness reduction mod the candidate, the split of candidate-1, then
// modular products from the one shared bit-serial multiplier.
// Reset is asynchronous, active low, and returns the controller to idle.
// The result holds on m_axis until taken; a new item is taken once it is.
module miller_rabin_witness_test
    import mrwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] candidate, [127:64] witness
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // [0] probable_prime, [2:1] verdict_code, rest 0
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;
    verdict_t   verdict;
    logic       in_fire, out_fire;

    assign s_axis_tready = ~busy;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = m_axis_tvalid & m_axis_tready;

    mrwt_datapath u_dp (
        .clk       (clk),
        .candidate (s_axis_tdata[NUM_WIDTH-1:0]),
        .witness   (s_axis_tdata[64 +: NUM_WIDTH]),
        .cmd       (cmd),
        .status    (status)
    );

    mrwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .verdict   (verdict)
    );

    assign m_axis_tdata = {5'b0, verdict, (verdict == VERDICT_PASS)};

    // no new item while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped before taken");

    // an accepted item makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("accepted item did not start work");

endmodule
